// File: src/lkv_pkg.sv
// lkv_pkg: shared constants for the LRU key/value cache.
// No dependencies; imported by the cell, the hit selector and the top level.
`timescale 1ns / 1ps

package lkv_pkg;

  // Field widths fixed by the interface
  localparam int VALUE_W = 31;
  localparam int OUT_W   = 32;
  localparam int CAP_W   = 5;

  // Capacity register reset value
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // Request opcodes
  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  // Returned on a get miss (-1)
  localparam logic signed [OUT_W-1:0] MISS_VALUE = -32'sd1;

endpackage

// File: src/lkv_cell.sv
// lkv_cell: one entry of the recency-ordered cell chain.
// Depends on lkv_pkg. Holds valid, key and value; loads from its upstream neighbor on shift.
`timescale 1ns / 1ps

module lkv_cell
  import lkv_pkg::*;
#(
  parameter int KW = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               shift_en,
  input  logic               up_valid,
  input  logic [KW-1:0]      up_key,
  input  logic [VALUE_W-1:0] up_value,
  input  logic [KW-1:0]      lookup_key,
  output logic               valid,
  output logic [KW-1:0]      entry_key,
  output logic [VALUE_W-1:0] entry_value,
  output logic               match
);

  // Valid bit: cleared at reset, follows upstream on shift
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (shift_en) begin
      valid <= up_valid;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk) begin
    if (shift_en) begin
      entry_key   <= up_key;
      entry_value <= up_value;
    end
  end

  // Associative compare
  assign match = valid && (entry_key == lookup_key);

endmodule

// File: src/lkv_hit_sel.sv
// lkv_hit_sel: turns the cell match vector into hit flag, position and value.
// Depends on lkv_pkg. At most one cell matches, so an AND-OR select suffices.
`timescale 1ns / 1ps

module lkv_hit_sel
  import lkv_pkg::*;
#(
  parameter int ENTRIES = 16,
  parameter int IDX_W   = 4
) (
  input  logic [ENTRIES-1:0] match,
  input  logic [VALUE_W-1:0] cell_value [ENTRIES],
  output logic               hit,
  output logic [IDX_W-1:0]   hit_pos,
  output logic [VALUE_W-1:0] hit_value
);

  // One-hot to binary position and value
  always_comb begin
    hit_pos   = '0;
    hit_value = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (match[i]) begin
        hit_pos   = hit_pos | IDX_W'(i);
        hit_value = hit_value | cell_value[i];
      end
    end
    hit = |match;
  end

endmodule

// File: src/lru_key_value_cache.sv
// lru_key_value_cache: top level of the LRU key/value cache.
// Depends on lkv_pkg, lkv_cell and lkv_hit_sel.
`timescale 1ns / 1ps

// Entries live in a chain of cells kept in recency order: cell 0 is the most
// recent, the valid entries fill cells 0 to count-1, and the last valid one is
// the eviction victim. The accept cycle compares the key against every cell at
// once; the update state then shifts the chain by one up to the hit cell (or
// up to the fill level on a put miss) and loads the entry into cell 0, while a
// get miss shifts nothing. Any request, get or put, holds in the update state
// while an earlier result is still unaccepted at the output register. Capacity
// 0 acts as 1 and values above ENTRIES act as ENTRIES; lowering it evicts nothing
// at once, a later put miss replaces the oldest entry. Reset clears the whole store.
module lru_key_value_cache
  import lkv_pkg::*;
#(
  parameter int ENTRIES  = 16,
  parameter int KEY_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    opcode,
  input  logic [15:0]             key,
  input  logic [VALUE_W-1:0]      value,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [OUT_W-1:0] read_value,
  input  logic                    cfg_wr_en,
  input  logic [CAP_W-1:0]        cfg_wr_data
);

  localparam int KW    = (KEY_BITS < 16) ? KEY_BITS : 16;
  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int EW    = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_UPD  = 1'b1;

  logic               state;
  logic [CAP_W-1:0]   capacity;
  logic [CNT_W-1:0]   count;

  // Request registers
  logic               op_r;
  logic [KW-1:0]      key_r;
  logic [VALUE_W-1:0] value_r;
  logic               hit_r;
  logic [IDX_W-1:0]   pos_r;
  logic [VALUE_W-1:0] hit_value_r;

  // Cell chain signals
  logic [ENTRIES-1:0] cell_valid;
  logic [ENTRIES-1:0] match;
  logic [KW-1:0]      cell_key   [ENTRIES];
  logic [VALUE_W-1:0] cell_value [ENTRIES];
  logic [ENTRIES-1:0] up_valid;
  logic [KW-1:0]      up_key     [ENTRIES];
  logic [VALUE_W-1:0] up_value   [ENTRIES];

  logic               hit;
  logic [IDX_W-1:0]   hit_pos;
  logic [VALUE_W-1:0] hit_value;

  logic               accept;
  logic               out_free;
  logic               step;
  logic               upd_go;
  logic               evict;
  logic [EW-1:0]      eff_cap;
  logic [CNT_W-1:0]   limit;
  logic [VALUE_W-1:0] head_value;
  logic [KW-1:0]      lookup_key;

  assign in_ready   = (state == S_IDLE);
  assign accept     = in_valid && in_ready;
  assign out_free   = !out_valid || out_ready;
  assign step       = (state == S_UPD) && out_free;
  assign lookup_key = key[KW-1:0];

  // Effective capacity and eviction decision
  always_comb begin
    if (capacity == '0) begin
      eff_cap = EW'(1);
    end else if (EW'(capacity) > EW'(ENTRIES)) begin
      eff_cap = EW'(ENTRIES);
    end else begin
      eff_cap = EW'(capacity);
    end
  end

  assign evict = (EW'(count) >= eff_cap);

  // Shift extent and entry loaded into the head cell
  always_comb begin
    if (hit_r) begin
      limit = CNT_W'(pos_r);
    end else if (evict) begin
      limit = count - CNT_W'(1);
    end else begin
      limit = count;
    end
  end

  assign head_value = (op_r == OP_PUT) ? value_r : hit_value_r;
  assign upd_go     = step && ((op_r == OP_PUT) || hit_r);

  // Cell chain
  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    logic shift_en;

    if (g == 0) begin : g_head
      assign up_valid[g] = 1'b1;
      assign up_key[g]   = key_r;
      assign up_value[g] = head_value;
    end else begin : g_body
      assign up_valid[g] = cell_valid[g-1];
      assign up_key[g]   = cell_key[g-1];
      assign up_value[g] = cell_value[g-1];
    end

    assign shift_en = upd_go && (CNT_W'(g) <= limit);

    lkv_cell #(
      .KW(KW)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .shift_en   (shift_en),
      .up_valid   (up_valid[g]),
      .up_key     (up_key[g]),
      .up_value   (up_value[g]),
      .lookup_key (lookup_key),
      .valid      (cell_valid[g]),
      .entry_key  (cell_key[g]),
      .entry_value(cell_value[g]),
      .match      (match[g])
    );
  end

  lkv_hit_sel #(
    .ENTRIES(ENTRIES),
    .IDX_W  (IDX_W)
  ) u_hit_sel (
    .match     (match),
    .cell_value(cell_value),
    .hit       (hit),
    .hit_pos   (hit_pos),
    .hit_value (hit_value)
  );

  // Capture request and lookup result on accept
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r        <= opcode;
      key_r       <= lookup_key;
      value_r     <= value;
      hit_r       <= hit;
      pos_r       <= hit_pos;
      hit_value_r <= hit_value;
    end
  end

  // Sequencer, fill count and capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      capacity <= CAP_RESET;
    end else begin
      if (cfg_wr_en) begin
        capacity <= cfg_wr_data;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_UPD;
          end
        end
        S_UPD: begin
          if (step) begin
            state <= S_IDLE;
            if ((op_r == OP_PUT) && !hit_r && !evict) begin
              count <= count + CNT_W'(1);
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step && (op_r == OP_GET)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && (op_r == OP_GET)) begin
      read_value <= hit_r ? signed'({1'b0, hit_value_r}) : MISS_VALUE;
    end
  end

  // Checks
  assert property (@(posedge clk) disable iff (rst)
    $countones(cell_valid) == int'(count))
    else $error("valid cells do not match fill count");

  assert property (@(posedge clk) disable iff (rst)
    $onehot0(match))
    else $error("key held in more than one cell");

  assert property (@(posedge clk) disable iff (rst)
    EW'(count) <= EW'(ENTRIES))
    else $error("fill count above entry count");

  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_UPD))
    else $error("result produced outside update cycle");

endmodule

// File: sim/tb_top.sv
// tb_top: self-checking testbench for lru_key_value_cache (get/put requests, capacity register).
// Depends on lkv_pkg and the RTL. A recency-ordered mirror of the cache predicts every get result.
`timescale 1ns / 1ps

import lkv_pkg::*;

typedef struct packed {
  logic [15:0]        k;
  logic [VALUE_W-1:0] v;
} kv_line_t;

// Mirror of the cache contents, most recent line first, plus the reads still owed
class cache_mirror;
  localparam int SLOTS = 16;

  kv_line_t                lines[$];
  logic signed [OUT_W-1:0] pending_reads[$];
  logic [CAP_W-1:0]        cap = CAP_RESET;
  int                      mismatches = 0;

  function void write_capacity(logic [CAP_W-1:0] c);
    cap = c;
  endfunction

  // Zero acts as one, anything above the slot count as the slot count
  function int held_limit();
    if (cap == 0) return 1;
    if (cap > SLOTS) return SLOTS;
    return cap;
  endfunction

  // Apply one accepted request; a get leaves the value it must return
  function void note_request(logic op, logic [15:0] k, logic [VALUE_W-1:0] v);
    int       hit;
    kv_line_t ln;
    hit = -1;
    foreach (lines[i])
      if (hit < 0 && lines[i].k == k) hit = i;
    if (op == OP_GET) begin
      if (hit < 0) begin
        pending_reads.push_back(MISS_VALUE);
      end else begin
        ln = lines[hit];
        lines.delete(hit);
        lines.push_front(ln);
        pending_reads.push_back({1'b0, ln.v});
      end
    end else begin
      ln.k = k;
      ln.v = v;
      if (hit >= 0) begin
        lines.delete(hit);
      end else if (lines.size() + 1 > held_limit() || lines.size() >= SLOTS) begin
        // oldest line goes; a lowered capacity drops only one per put miss
        void'(lines.pop_back());
      end
      lines.push_front(ln);
    end
  endfunction

  function void check_read(logic signed [OUT_W-1:0] got);
    logic signed [OUT_W-1:0] exp_val;
    if (pending_reads.size() == 0) begin
      $display("%0t: unexpected read_value %0d, no get outstanding", $time, got);
      mismatches++;
    end else begin
      exp_val = pending_reads.pop_front();
      if (got !== exp_val) begin
        $display("%0t: read_value expected %0d, actual %0d", $time, exp_val, got);
        mismatches++;
      end
    end
  endfunction
endclass

module tb_top;

  localparam int RUN_LIMIT = 200000;
  localparam int POOL_MAX  = 20;

  logic                    clk = 1'b0;
  logic                    rst;
  logic                    in_valid;
  logic                    in_ready;
  logic                    opcode;
  logic [15:0]             key;
  logic [VALUE_W-1:0]      value;
  logic                    out_valid;
  logic                    out_ready;
  logic signed [OUT_W-1:0] read_value;
  logic                    cfg_wr_en;
  logic [CAP_W-1:0]        cfg_wr_data;

  cache_mirror mirror = new();
  bit          steady_in  = 1'b0;
  bit          steady_out = 1'b0;

  lru_key_value_cache i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .opcode      (opcode),
    .key         (key),
    .value       (value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .read_value  (read_value),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #1 clk = ~clk;

  function automatic int draw_gap(bit steady);
    if (steady) return 0;
    return $urandom_range(0, 11);
  endfunction

  // Present one request and hold it until accepted; valid stays high afterward
  task automatic send_request(input logic op, input logic [15:0] k,
                              input logic [VALUE_W-1:0] v);
    int gap;
    gap = draw_gap(steady_in);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode   <= op;
    key      <= k;
    value    <= v;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    mirror.note_request(op, k, v);
  endtask

  // Drain: no read owed, then room for a trailing put to finish
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (mirror.pending_reads.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_capacity(input logic [CAP_W-1:0] c);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= c;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    mirror.write_capacity(c);
  endtask

  // Mostly keys from a small working set so hits, updates and evictions all occur
  task automatic random_phase(input int n);
    logic [15:0]        pool[POOL_MAX];
    int                 pool_n;
    logic [15:0]        k;
    logic [VALUE_W-1:0] v;
    pool_n     = $urandom_range(2, POOL_MAX);
    steady_in  = ($urandom_range(0, 3) == 0);
    steady_out = ($urandom_range(0, 3) == 0);
    foreach (pool[i]) pool[i] = 16'($urandom);
    repeat (n) begin
      if ($urandom_range(0, 4) != 0) k = pool[$urandom_range(0, pool_n - 1)];
      else k = 16'($urandom);
      case ($urandom_range(0, 9))
        0:       v = '0;
        1:       v = '1;
        default: v = VALUE_W'($urandom);
      endcase
      send_request(($urandom_range(0, 1) == 1) ? OP_PUT : OP_GET, k, v);
    end
  endtask

  // Result side: random stalls on out_ready, check each accepted read
  initial begin
    logic signed [OUT_W-1:0] got;
    int                      gap;
    out_ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      gap = draw_gap(steady_out);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(negedge clk); while (!out_valid);
      got = read_value;
      @(posedge clk);
      mirror.check_read(got);
    end
  end

  // Watchdog
  initial begin
    repeat (RUN_LIMIT) @(posedge clk);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    logic [CAP_W-1:0] caps[10];
    rst         <= 1'b1;
    in_valid    <= 1'b0;
    opcode      <= OP_GET;
    key         <= '0;
    value       <= '0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty store, key extremes, value extremes, put hit at reset capacity
    send_request(OP_GET, 16'h0000, '0);
    send_request(OP_GET, 16'hFFFF, '0);
    send_request(OP_PUT, 16'h0000, '0);
    send_request(OP_PUT, 16'hFFFF, '1);
    send_request(OP_GET, 16'h0000, '0);
    send_request(OP_GET, 16'hFFFF, '0);
    send_request(OP_PUT, 16'h0000, 31'd5);
    send_request(OP_GET, 16'h0000, '0);

    // Capacity two: put miss on a full store evicts the least recent
    wait_idle();
    set_capacity(5'd2);
    send_request(OP_PUT, 16'h0003, 31'd123);
    send_request(OP_GET, 16'hFFFF, '0);
    send_request(OP_GET, 16'h0000, '0);
    send_request(OP_PUT, 16'h0004, 31'h2AAAAAAA);
    send_request(OP_GET, 16'h0003, '0);

    // Capacity zero acts as one, set below the count: only a put miss evicts, one line
    wait_idle();
    set_capacity(5'd0);
    send_request(OP_GET, 16'h0004, '0);
    send_request(OP_PUT, 16'h0004, '1);
    send_request(OP_PUT, 16'h0005, 31'd1);
    send_request(OP_GET, 16'h0000, '0);
    send_request(OP_GET, 16'h0004, '0);
    send_request(OP_GET, 16'h0005, '0);

    // Random phases over a range of capacities, extremes included
    caps = '{5'd31, 5'd4, 5'd1, 5'd16, 5'd0, 5'd9, 5'd2, 5'd17, 5'd3, 5'd0};
    caps[9] = CAP_W'($urandom_range(0, 31));
    foreach (caps[i]) begin
      wait_idle();
      set_capacity(caps[i]);
      random_phase(75);
    end

    wait_idle();
    repeat (6) @(posedge clk);
    if (mirror.mismatches == 0 && mirror.pending_reads.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
